FILE: sv/fvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fvc_pkg;
  localparam int NodeDepthDef = 1024;
  localparam int FeatureSlotsDef = 16;
  localparam int MaxTreesDef = 64;
  localparam int ClassCountDef = 8;
  localparam int WalkLimitDef = 16;

  localparam logic [1:0] FuncNode = 2'd0;
  localparam logic [1:0] FuncFeat = 2'd1;
  localparam logic [1:0] FuncClass = 2'd2;
  localparam logic [1:0] FuncRoot = 2'd3;

  localparam int NodeW = 63;

  typedef enum logic [2:0] {
    StIdle,
    StRoot,
    StNode,
    StEval,
    StScan,
    StOut
  } state_e;
endpackage
`default_nettype wire

FILE: sv/fvc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fvc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: sv/forest_vote_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | handshake      | payload
// cfg      | in        | valid / ready  | tree_count
// in       | in        | valid / stall  | func and node, feature, root fields
// out      | out       | valid / stall  | predicted_class, top_votes
// a classify walks each counted tree in turn; its run time is set by the registered node memory
// read and the feature read per split
// vote counters are swept once at the end of the classify, one class per cycle
// reset clears state, tree index, tree count and vote counters; stores hold garbage until written
// a stalled result holds the block from accepting the next item
module forest_vote_classifier #(
  parameter int NODE_DEPTH = fvc_pkg::NodeDepthDef,
  parameter int FEATURE_SLOTS = fvc_pkg::FeatureSlotsDef,
  parameter int MAX_TREES = fvc_pkg::MaxTreesDef,
  parameter int CLASS_COUNT = fvc_pkg::ClassCountDef,
  parameter int WALK_LIMIT = fvc_pkg::WalkLimitDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [6:0]         cfg_tree_count_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [9:0]         node_address_i,
  input  wire logic signed [4:0]  split_feature_i,
  input  wire logic signed [31:0] split_threshold_i,
  input  wire logic [3:0]         leaf_label_i,
  input  wire logic signed [10:0] left_index_i,
  input  wire logic signed [10:0] right_index_i,
  input  wire logic [5:0]         tree_number_i,
  input  wire logic [3:0]         feature_index_i,
  input  wire logic signed [31:0] feature_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [3:0]              predicted_class_o,
  output logic [6:0]              top_votes_o
);
  import fvc_pkg::*;

  localparam int NAW = $clog2(NODE_DEPTH);
  localparam int FAW = (FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1;
  localparam int FDP = (FEATURE_SLOTS > 1) ? FEATURE_SLOTS : 2;
  localparam int TAW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int TDP = (MAX_TREES > 1) ? MAX_TREES : 2;
  localparam int CAW = $clog2(CLASS_COUNT);
  localparam int SW = $clog2(WALK_LIMIT + 1);
  localparam int TCW = $clog2(MAX_TREES + 1);

  state_e state_q, state_d;
  logic [6:0] tree_count_q;
  logic [TCW-1:0] trees_q, tree_q, tree_d;
  logic [SW-1:0] steps_q, steps_d;
  logic [6:0] votes_q [CLASS_COUNT];
  logic [CAW:0] scan_q, scan_d;
  logic [3:0] best_q, best_d;
  logic [6:0] top_q, top_d;
  logic vote_en;
  logic [CAW-1:0] vote_cls;
  logic clr_votes;

  logic acc;
  assign acc = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  logic node_we;
  logic [NAW-1:0] node_raddr, node_waddr;
  logic [NodeW-1:0] node_wdata, node_rdata;
  assign node_we = acc && func_i == FuncNode && {6'd0, node_address_i} < 16'(NODE_DEPTH);
  assign node_waddr = NAW'(node_address_i);
  assign node_wdata = {split_feature_i, split_threshold_i, leaf_label_i, left_index_i,
                       right_index_i};
  fvc_ram #(.Width(NodeW), .Depth(NODE_DEPTH)) u_node (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(node_raddr), .rdata_o(node_rdata));

  logic root_we;
  logic [9:0] root_rdata;
  assign root_we = acc && func_i == FuncRoot && {5'd0, tree_number_i} < 11'(MAX_TREES);
  fvc_ram #(.Width(10), .Depth(TDP)) u_root (
    .clk_i, .we_i(root_we), .waddr_i(TAW'(tree_number_i)), .wdata_i(node_address_i),
    .raddr_i(TAW'(tree_d)), .rdata_o(root_rdata));

  logic feat_we;
  logic [FAW-1:0] feat_raddr;
  logic signed [31:0] feat_rdata;
  assign feat_we = acc && func_i == FuncFeat && {3'd0, feature_index_i} < 7'(FEATURE_SLOTS);
  fvc_ram #(.Width(32), .Depth(FDP)) u_feat (
    .clk_i, .we_i(feat_we), .waddr_i(FAW'(feature_index_i)), .wdata_i(feature_value_i),
    .raddr_i(feat_raddr), .rdata_o(feat_rdata));

  logic signed [4:0] n_feat;
  logic signed [31:0] n_thr;
  logic [3:0] n_lab;
  logic signed [10:0] n_l, n_r;
  assign {n_feat, n_thr, n_lab, n_l, n_r} = node_rdata;
  assign feat_raddr = FAW'(n_feat);

  logic [NAW-1:0] addr_q, addr_d;
  logic signed [10:0] nxt;
  logic nxt_ok;
  // node memory rereads the same address, so the node is still on rdata
  assign nxt = (feat_rdata < n_thr) ? n_l : n_r;
  assign nxt_ok = !nxt[10] && 16'(nxt) < 16'(NODE_DEPTH);
  assign node_raddr = addr_d;

  always_comb begin
    state_d = state_q;
    tree_d = tree_q;
    steps_d = steps_q;
    addr_d = addr_q;
    scan_d = scan_q;
    best_d = best_q;
    top_d = top_q;
    vote_en = 1'b0;
    vote_cls = CAW'(n_lab);
    clr_votes = 1'b0;
    in_stall_o = state_q != StIdle;
    case (state_q)
      StIdle: begin
        if (acc && func_i == FuncClass) begin
          tree_d = '0;
          state_d = StRoot;
        end
      end
      StRoot: begin
        steps_d = '0;
        if (tree_q >= trees_q) begin
          scan_d = '0;
          best_d = 4'(CLASS_COUNT);
          top_d = '0;
          state_d = StScan;
        end else if (16'(root_rdata) < 16'(NODE_DEPTH)) begin
          addr_d = NAW'(root_rdata);
          state_d = StNode;
        end else begin
          tree_d = tree_q + 1'b1;
        end
      end
      StNode: begin
        if (n_feat < 0) begin
          vote_en = {1'b0, n_lab} < 5'(CLASS_COUNT);
          tree_d = tree_q + 1'b1;
          state_d = StRoot;
        end else if (steps_q >= SW'(WALK_LIMIT) || 7'(n_feat) >= 7'(FEATURE_SLOTS)) begin
          tree_d = tree_q + 1'b1;
          state_d = StRoot;
        end else begin
          state_d = StEval;
        end
      end
      StEval: begin
        if (nxt_ok) begin
          addr_d = NAW'(nxt);
          steps_d = steps_q + 1'b1;
          state_d = StNode;
        end else begin
          tree_d = tree_q + 1'b1;
          state_d = StRoot;
        end
      end
      StScan: begin
        if (votes_q[CAW'(scan_q)] > top_q) begin
          top_d = votes_q[CAW'(scan_q)];
          best_d = 4'(scan_q);
        end
        scan_d = scan_q + 1'b1;
        if (scan_q == (CAW+1)'(CLASS_COUNT - 1)) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          clr_votes = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tree_count_q <= '0;
      tree_q <= '0;
      for (int i = 0; i < CLASS_COUNT; i++) votes_q[i] <= '0;
    end else begin
      state_q <= state_d;
      tree_q <= tree_d;
      if (cfg_valid_i) begin
        tree_count_q <= cfg_tree_count_i;
      end
      if (clr_votes) begin
        for (int i = 0; i < CLASS_COUNT; i++) votes_q[i] <= '0;
      end else if (vote_en) begin
        votes_q[vote_cls] <= votes_q[vote_cls] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d;
    addr_q <= addr_d;
    scan_q <= scan_d;
    best_q <= best_d;
    top_q <= top_d;
    trees_q <= (32'(tree_count_q) > 32'(MAX_TREES)) ? TCW'(MAX_TREES) : TCW'(tree_count_q);
  end

  assign out_valid_o = state_q == StOut;
  assign predicted_class_o = best_q;
  assign top_votes_o = top_q;
endmodule
`default_nettype wire

FILE: sv/fvc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fvc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [3:0] predicted_class_o,
  input wire logic [6:0] top_votes_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(predicted_class_o))
    else $error("result changed under stall");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_unk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && predicted_class_o == 4'd8 |-> top_votes_o == 7'd0)
    else $error("unknown with votes");
  a_vote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && predicted_class_o != 4'd8 |-> top_votes_o != 7'd0)
    else $error("class without votes");
endmodule

bind forest_vote_classifier fvc_checker u_fvc_checker (.*);
`default_nettype wire

FILE: tb/sv/forest_vote_checker.sv
`timescale 1ns / 1ps
module forest_vote_checker
  import fvc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [6:0]         cfg_tree_count_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         func_i,
  input  logic [9:0]         node_address_i,
  input  logic signed [4:0]  split_feature_i,
  input  logic signed [31:0] split_threshold_i,
  input  logic [3:0]         leaf_label_i,
  input  logic signed [10:0] left_index_i,
  input  logic signed [10:0] right_index_i,
  input  logic [5:0]         tree_number_i,
  input  logic [3:0]         feature_index_i,
  input  logic signed [31:0] feature_value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [3:0]         predicted_class_i,
  input  logic [6:0]         top_votes_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  typedef struct packed {
    logic signed [4:0]  feat;
    logic signed [31:0] thresh;
    logic [3:0]         label;
    logic signed [10:0] left;
    logic signed [10:0] right;
  } tree_node_t;

  typedef struct packed {
    logic [3:0] cls;
    logic [6:0] votes;
  } vote_result_t;

  tree_node_t         nodes [NodeDepthDef];
  logic [9:0]         roots [MaxTreesDef];
  logic signed [31:0] features [FeatureSlotsDef];
  logic [6:0]         trees_used;
  vote_result_t       expected_votes [$];

  function automatic logic [3:0] leaf_class(input logic [9:0] root);
    int addr;
    int steps;
    tree_node_t n;
    addr = root;
    steps = 0;
    while (1) begin
      if (addr < 0 || addr >= NodeDepthDef) return 4'(ClassCountDef);
      n = nodes[addr];
      if (n.feat < 0) return (n.label < ClassCountDef) ? n.label : 4'(ClassCountDef);
      if (steps >= WalkLimitDef || n.feat >= FeatureSlotsDef) return 4'(ClassCountDef);
      addr = (features[n.feat] < n.thresh) ? int'(n.left) : int'(n.right);
      steps++;
    end
  endfunction

  function automatic vote_result_t vote_forest();
    int tally [ClassCountDef];
    int n_trees;
    logic [3:0] cls;
    vote_result_t r;
    foreach (tally[c]) tally[c] = 0;
    n_trees = (trees_used > MaxTreesDef) ? MaxTreesDef : trees_used;
    for (int t = 0; t < n_trees; t++) begin
      cls = leaf_class(roots[t]);
      if (cls < ClassCountDef) tally[cls]++;
    end
    r.cls = 4'(ClassCountDef);
    r.votes = '0;
    for (int c = 0; c < ClassCountDef; c++) begin
      if (tally[c] > r.votes) begin
        r.votes = 7'(tally[c]);
        r.cls = 4'(c);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    vote_result_t want;
    if (!rst_ni) begin
      trees_used = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) trees_used = cfg_tree_count_i;
      if (in_valid_i && !in_stall_i) begin
        case (func_i)
          FuncNode: nodes[node_address_i] = '{split_feature_i, split_threshold_i,
                                              leaf_label_i, left_index_i, right_index_i};
          FuncFeat: features[feature_index_i] = feature_value_i;
          FuncRoot: roots[tree_number_i] = node_address_i;
          default: expected_votes = {expected_votes, vote_forest()};
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_votes.size() == 0) begin
          report_mismatch("unexpected result, class", predicted_class_i, -1);
        end else begin
          want = expected_votes.pop_front();
          if (predicted_class_i !== want.cls)
            report_mismatch("predicted_class", predicted_class_i, want.cls);
          if (top_votes_i !== want.votes)
            report_mismatch("top_votes", top_votes_i, want.votes);
        end
      end
      pending_o = expected_votes.size();
    end
  end
endmodule

FILE: tb/sv/forest_vote_classifier_test.sv
`timescale 1ns / 1ps
module forest_vote_classifier_test;
  import fvc_pkg::*;

  localparam int IdleLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [6:0]         cfg_tree_count_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i = FuncNode;
  logic [9:0]         node_address_i = '0;
  logic signed [4:0]  split_feature_i = '0;
  logic signed [31:0] split_threshold_i = '0;
  logic [3:0]         leaf_label_i = '0;
  logic signed [10:0] left_index_i = '0;
  logic signed [10:0] right_index_i = '0;
  logic [5:0]         tree_number_i = '0;
  logic [3:0]         feature_index_i = '0;
  logic signed [31:0] feature_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic [3:0]         predicted_class_o;
  logic [6:0]         top_votes_o;
  int                 fail_count;
  int                 pending;

  bit                 quiet;
  bit [1023:0]        node_written;
  int                 written_nodes [$];
  int                 idle_cycles;
  logic [6:0]         phase_counts [6];

  always #10 clk_i = ~clk_i;

  forest_vote_classifier i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_tree_count_i,
    .in_valid_i, .in_stall_o, .func_i, .node_address_i, .split_feature_i,
    .split_threshold_i, .leaf_label_i, .left_index_i, .right_index_i,
    .tree_number_i, .feature_index_i, .feature_value_i,
    .out_valid_o, .out_stall_i, .predicted_class_o, .top_votes_o
  );

  forest_vote_checker i_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_tree_count_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .node_address_i, .split_feature_i,
    .split_threshold_i, .leaf_label_i, .left_index_i, .right_index_i,
    .tree_number_i, .feature_index_i, .feature_value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .predicted_class_i(predicted_class_o),
    .top_votes_i(top_votes_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[forest_vote_classifier] ERROR");
      $finish;
    end
  end

  // result side stall per item
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = quiet ? 0 : $urandom_range(0, 19);
      out_stall_i = (w > 0);
      repeat (w) @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'sh8000_0000;
    if (r < 10) return 32'sh7fff_ffff;
    if (r < 13) return 0;
    if (r < 16) return -1;
    if (r < 50) return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    return $urandom;
  endfunction

  function automatic logic signed [10:0] pick_child();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 11'(written_nodes[$urandom_range(0, written_nodes.size() - 1)]);
    if (r < 90) return -1;
    return -11'($urandom_range(2, 1024));
  endfunction

  function automatic logic [9:0] pick_root();
    return 10'(written_nodes[$urandom_range(0, written_nodes.size() - 1)]);
  endfunction

  task automatic send(input logic [1:0] f, input logic [9:0] na, input logic signed [4:0] sf,
                      input logic signed [31:0] th, input logic [3:0] lb,
                      input logic signed [10:0] li, input logic signed [10:0] ri,
                      input logic [5:0] tn, input logic [3:0] fi,
                      input logic signed [31:0] fv);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    repeat (gap) @(negedge clk_i);
    func_i = f;
    node_address_i = na;
    split_feature_i = sf;
    split_threshold_i = th;
    leaf_label_i = lb;
    left_index_i = li;
    right_index_i = ri;
    tree_number_i = tn;
    feature_index_i = fi;
    feature_value_i = fv;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_node(input logic [9:0] addr, input logic signed [4:0] sf,
                            input logic signed [31:0] th, input logic [3:0] lb,
                            input logic signed [10:0] li, input logic signed [10:0] ri);
    send(FuncNode, addr, sf, th, lb, li, ri, $urandom, $urandom, $urandom);
  endtask

  task automatic mark_node(input int addr);
    if (!node_written[addr]) begin
      node_written[addr] = 1'b1;
      written_nodes = {written_nodes, addr};
    end
  endtask

  task automatic random_node();
    logic [9:0] addr;
    logic signed [4:0] sf;
    addr = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, 63)) : 10'($urandom);
    mark_node(addr);
    sf = ($urandom_range(0, 99) < 65) ? 5'($urandom_range(0, 15))
                                      : -5'($urandom_range(1, 16));
    write_node(addr, sf, pick_value(), $urandom, pick_child(), pick_child());
  endtask

  task automatic classify();
    send(FuncClass, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) random_node();
    else if (r < 50)
      send(FuncFeat, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, pick_value());
    else if (r < 65)
      send(FuncRoot, pick_root(), $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom);
    else classify();
  endtask

  task automatic write_tree_count(input logic [6:0] value);
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    cfg_tree_count_i = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    idle_cycles = 0;
    quiet = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // bring-up: every feature slot, one leaf, every root on it
    quiet = 1'b1;
    for (int s = 0; s < FeatureSlotsDef; s++)
      send(FuncFeat, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, 4'(s), pick_value());
    mark_node(0);
    write_node(0, -1, 0, 0, -1, -1);
    for (int t = 0; t < MaxTreesDef; t++)
      send(FuncRoot, 0, $urandom, $urandom, $urandom, $urandom, $urandom,
           6'(t), $urandom, $urandom);
    quiet = 1'b0;

    // no trees voting
    classify();

    // leaf out of class range, extreme threshold, missing child, self loop
    mark_node(1023);
    write_node(1023, -16, 32'sh7fff_ffff, 4'd15, 11'sd1023, -11'sd1024);
    mark_node(1);
    write_node(1, 5'sd15, 32'sh8000_0000, 4'd0, -11'sd1, 11'sd1023);
    mark_node(2);
    write_node(2, 5'sd0, 32'sh7fff_ffff, 4'd8, -11'sd1, -11'sd1);
    mark_node(3);
    write_node(3, 5'sd0, 32'sh0, 4'd3, 11'sd3, 11'sd3);
    mark_node(4);
    write_node(4, -5'sd1, 32'sh0, 4'd7, 11'sd0, 11'sd0);
    send(FuncFeat, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, 4'd0, 32'sh8000_0000);
    send(FuncRoot, 10'd1, 0, 0, 0, 0, 0, 6'd0, 0, 0);
    send(FuncRoot, 10'd2, 0, 0, 0, 0, 0, 6'd1, 0, 0);
    send(FuncRoot, 10'd3, 0, 0, 0, 0, 0, 6'd2, 0, 0);
    send(FuncRoot, 10'd1023, 0, 0, 0, 0, 0, 6'd3, 0, 0);
    send(FuncRoot, 10'd4, 0, 0, 0, 0, 0, 6'd63, 0, 0);
    send(FuncRoot, 10'd4, 0, 0, 0, 0, 0, 6'd4, 0, 0);

    phase_counts = '{7'd4, 7'd64, 7'd127, 7'd1, 7'd0, 7'($urandom_range(2, 40))};
    foreach (phase_counts[p]) begin
      write_tree_count(phase_counts[p]);
      classify();
      for (int i = 0; i < 75; i++) begin
        if (i % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
        random_item();
      end
      quiet = 1'b0;
    end

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[forest_vote_classifier] OK");
    end else begin
      $display("[forest_vote_classifier] ERROR");
    end
    $finish;
  end
endmodule

FILE: forest_vote_classifier.f
sv/fvc_pkg.sv
sv/fvc_ram.sv
sv/forest_vote_classifier.sv
sv/fvc_checker.sv
tb/sv/forest_vote_checker.sv
tb/sv/forest_vote_classifier_test.sv
